>>> rtl/bso_pkg.sv
// ----------------------------------------------------------------------------
// bso_pkg
// Shared types and codes for the bitmap set operations core.
// ----------------------------------------------------------------------------
package bso_pkg;

  // Field widths of one item and one result
  localparam int unsigned OP_W    = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned ELEM_W  = 7;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // Bits of each bitmap handled per scan cycle
  localparam int unsigned CHUNK_W = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_A  = 2'd1;
  localparam logic [OP_W-1:0] OP_INS_B  = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

  // Derived set codes
  localparam logic [KIND_W-1:0] KIND_AND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIFF = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // take a new item, apply its op, restart the scan
    logic scan;      // fold the current chunk into the running result
    logic load_out;  // move the finished result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_chunk;
  } sts_t;

endpackage

>>> rtl/bitmap_set_operations_core.sv
// ----------------------------------------------------------------------------
// bitmap_set_operations_core
// Two membership bitmaps with intersection, union and difference queries.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Fields (tdata, lowest bit first)
// s_axis    in   op[1:0], set_kind[3:2], element[10:4], zero[15:11]
// m_axis    out  member_count[7:0], found[8], next_member[15:9]
//
// An item is accepted, scanned chunk by chunk and then moved into the
// output register, with NCHUNK = ceil(UNIVERSE_SIZE / 8) chunks. Its result
// turns valid as that register loads, and no next item is taken until the
// previous one has been moved there. The chunk scanner folds 8 bitmap bits
// per cycle into the popcount and the ascending member search. Reset
// empties both sets at once. The output register frees the scanner: a new
// item is taken while a result waits, and only the final hand-off stalls
// when the previous result is still unread.
//
module bitmap_set_operations_core #(
  parameter int unsigned UNIVERSE_SIZE = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // op, set_kind, element (from bit 0 up), zero padded
  input  logic [bso_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // member_count, found, next_member (from bit 0 up)
  output logic [bso_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i
);
  import bso_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [OP_W-1:0]    op;
  logic [KIND_W-1:0]  set_kind;
  logic [ELEM_W-1:0]  element;
  logic [COUNT_W-1:0] member_count;
  logic               found;
  logic [ELEM_W-1:0]  next_member;

  // Unpack the input item
  assign op       = s_axis_tdata_i[OP_W-1:0];
  assign set_kind = s_axis_tdata_i[OP_W +: KIND_W];
  assign element  = s_axis_tdata_i[OP_W + KIND_W +: ELEM_W];

  bso_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bso_datapath #(
    .UNIVERSE_SIZE (UNIVERSE_SIZE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op),
    .set_kind_i     (set_kind),
    .element_i      (element),
    .sts_o          (sts),
    .member_count_o (member_count),
    .found_o        (found),
    .next_member_o  (next_member)
  );

  // Pack the result; the three fields fill the 16 bits exactly
  assign m_axis_tdata_o = {next_member, found, member_count};

endmodule

>>> rtl/bso_datapath.sv
// ----------------------------------------------------------------------------
// bso_datapath
// Set bitmaps, chunk scanner with popcount and priority search, result regs.
// ----------------------------------------------------------------------------
module bso_datapath #(
  parameter int unsigned UNIVERSE_SIZE = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bso_pkg::cmd_t                cmd_i,
  input  logic [bso_pkg::OP_W-1:0]     op_i,
  input  logic [bso_pkg::KIND_W-1:0]   set_kind_i,
  input  logic [bso_pkg::ELEM_W-1:0]   element_i,
  output bso_pkg::sts_t                sts_o,
  output logic [bso_pkg::COUNT_W-1:0]  member_count_o,
  output logic                         found_o,
  output logic [bso_pkg::ELEM_W-1:0]   next_member_o
);
  import bso_pkg::*;

  localparam int unsigned NCHUNK = (UNIVERSE_SIZE + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned IDX_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned PAD_W  = NCHUNK * CHUNK_W;
  localparam int unsigned CNT_INC_W = $clog2(CHUNK_W + 1);

  logic [PAD_W-1:0]   first_q, first_d, second_q, second_d, ins_mask;
  logic [KIND_W-1:0]  kind_q;
  logic [ELEM_W-1:0]  elem_q;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               found_q, found_d;
  logic [ELEM_W-1:0]  next_q, next_d;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_found_q;
  logic [ELEM_W-1:0]  out_next_q;

  logic [CHUNK_W-1:0]   a_chunk, b_chunk, der, hit;
  logic [CNT_INC_W-1:0] pop;
  logic [COUNT_W:0]     sum;
  logic                 chunk_hit;
  int unsigned          hit_pos;

  // Decode the insert position; positions past the universe never get set
  always_comb begin
    for (int k = 0; k < PAD_W; k++) begin
      ins_mask[k] = (int'(element_i) == k) && (k < UNIVERSE_SIZE);
    end
  end

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    if (cmd_i.accept) begin
      unique case (op_i)
        OP_CLEAR: begin
          first_d  = '0;
          second_d = '0;
        end
        OP_INS_A: first_d  = first_q | ins_mask;
        OP_INS_B: second_d = second_q | ins_mask;
        default:  ;
      endcase
    end
  end

  // Derived membership of the current chunk
  assign a_chunk = first_q[idx_q*CHUNK_W +: CHUNK_W];
  assign b_chunk = second_q[idx_q*CHUNK_W +: CHUNK_W];

  always_comb begin
    case (kind_q)
      KIND_AND:  der = a_chunk & b_chunk;
      KIND_OR:   der = a_chunk | b_chunk;
      KIND_DIFF: der = a_chunk & ~b_chunk;
      default:   der = '0;
    endcase
  end

  always_comb begin
    pop       = '0;
    chunk_hit = 1'b0;
    hit_pos   = 0;
    for (int j = 0; j < CHUNK_W; j++) begin
      hit[j] = der[j] && ((int'(idx_q) * CHUNK_W + j) >= int'(elem_q));
      pop    = pop + CNT_INC_W'(der[j]);
    end
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        chunk_hit = 1'b1;
        hit_pos   = int'(idx_q) * CHUNK_W + j;
      end
    end
  end

  assign sum = {1'b0, count_q} + (COUNT_W + 1)'(pop);

  always_comb begin
    idx_d   = idx_q;
    count_d = count_q;
    found_d = found_q;
    next_d  = next_q;
    if (cmd_i.accept) begin
      idx_d   = '0;
      count_d = '0;
      found_d = 1'b0;
      next_d  = '0;
    end else if (cmd_i.scan) begin
      idx_d   = idx_q + 1'b1;
      count_d = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
      if (!found_q && chunk_hit) begin
        found_d = 1'b1;
        next_d  = ELEM_W'(hit_pos);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      idx_q    <= '0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    found_q <= found_d;
    next_q  <= next_d;
    if (cmd_i.accept) begin
      kind_q <= set_kind_i;
      elem_q <= element_i;
    end
    if (cmd_i.load_out) begin
      out_count_q <= count_q;
      out_found_q <= found_q;
      out_next_q  <= next_q;
    end
  end

  assign sts_o.last_chunk = (idx_q == IDX_W'(NCHUNK - 1));
  assign member_count_o   = out_count_q;
  assign found_o          = out_found_q;
  assign next_member_o    = out_next_q;

endmodule

>>> rtl/bso_ctrl.sv
// ----------------------------------------------------------------------------
// bso_ctrl
// Sequencer: accept an item, step the chunk scan, hand off the result.
// ----------------------------------------------------------------------------
module bso_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bso_pkg::sts_t sts_i,
  output bso_pkg::cmd_t cmd_o
);
  import bso_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last_chunk) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold the result until the output register frees up
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/bso_checker.sv
// ----------------------------------------------------------------------------
// bso_checker
// Port-level assertions for the bitmap set operations core.
// ----------------------------------------------------------------------------
module bso_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [bso_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i
);
  import bso_pkg::*;

  // The scan owns the block after an accept: no second item next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("item accepted while scan still running");

  // No result can appear in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !(m_axis_tvalid_o && !m_axis_tready_i)
    |=> !m_axis_tvalid_o)
    else $error("result issued without a scan");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // A miss reports next_member zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[COUNT_W] |->
    m_axis_tdata_o[COUNT_W+1 +: ELEM_W] == '0)
    else $error("next_member nonzero without a hit");

endmodule

bind bitmap_set_operations_core bso_checker u_bso_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

>>> tb/tb_bitmap_set_operations_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_set_operations_core
// Self-checking stream testbench for the bitmap set operations core.
// ----------------------------------------------------------------------------
// Builds a list of items up front: a directed opening, then random phases.
// Phases often clear the sets, fill them and walk the members in ascending
// order. A behavioral copy of both bitmaps predicts every result when its item
// is accepted. The receiver stalls on a rotating ready pattern, the sender
// works in bursts, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_bitmap_set_operations_core;
  import bso_pkg::*;

  localparam int unsigned UNIVERSE    = 128;
  localparam int unsigned ITEM_TARGET = 650;
  localparam int unsigned DRAIN_WAIT  = 40;      // well above one item's latency through the core
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef logic [UNIVERSE-1:0] bitmap_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KIND_W-1:0] set_kind;
    logic [ELEM_W-1:0] element;
  } set_item_t;

  // Packed in m_axis tdata order: member_count lowest, next_member highest
  typedef struct packed {
    logic [ELEM_W-1:0]  next_member;
    logic               found;
    logic [COUNT_W-1:0] member_count;
  } set_result_t;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  // op, set_kind, element (from bit 0 up), zero padded
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // member_count, found, next_member (from bit 0 up)
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;

  bitmap_set_operations_core #(
    .UNIVERSE_SIZE(UNIVERSE)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  always #6 clk_i = ~clk_i;

  // Items waiting for the driver, and results waiting for the checker
  set_item_t   pending_items[$];
  set_result_t expected_results[$];

  // Bitmaps as the block should hold them, advanced on each accepted item
  bitmap_t first_bits  = '0;
  bitmap_t second_bits = '0;
  // Bitmaps as the generator sees them while it builds the item list
  bitmap_t gen_first   = '0;
  bitmap_t gen_second  = '0;

  int unsigned items_total    = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned clears_sent    = 0;
  int unsigned queries_sent   = 0;
  int unsigned misses_seen    = 0;
  int unsigned max_count_seen = 0;

  // Apply the item's effect on both sets; a query changes nothing, nor does inserting a present member.
  function automatic void apply_set_op(input set_item_t it, ref bitmap_t a, ref bitmap_t b);
    case (it.op)
      OP_CLEAR: begin
        a = '0;
        b = '0;
      end
      OP_INS_A: a[it.element] = 1'b1;
      OP_INS_B: b[it.element] = 1'b1;
      default: ;
    endcase
  endfunction

  // Count the derived set and find its smallest member at or above element.
  function automatic set_result_t derive_set_result(input bitmap_t a, input bitmap_t b,
                                                    input logic [KIND_W-1:0] kind,
                                                    input logic [ELEM_W-1:0] element);
    bitmap_t     derived;
    set_result_t res;
    res = '0;
    case (kind)
      KIND_AND:  derived = a & b;
      KIND_OR:   derived = a | b;
      KIND_DIFF: derived = a & ~b;
      default:   derived = '0;  // unused kind reports an empty set
    endcase
    for (int i = 0; i < UNIVERSE; i++) begin
      if (derived[i]) begin
        res.member_count = res.member_count + 1'b1;
        if (!res.found && i >= element) begin
          res.found       = 1'b1;
          res.next_member = ELEM_W'(i);
        end
      end
    end
    return res;
  endfunction

  // Queue one item and return what it will report
  task automatic add_item(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] kind,
                          input logic [ELEM_W-1:0] element, output set_result_t res);
    set_item_t it;
    it.op       = op;
    it.set_kind = kind;
    it.element  = element;
    apply_set_op(it, gen_first, gen_second);
    res = derive_set_result(gen_first, gen_second, kind, element);
    pending_items.push_back(it);
    items_total++;
  endtask

  // Walk members upward with element = previous member + 1
  task automatic walk_members(input logic [KIND_W-1:0] kind, input logic [ELEM_W-1:0] start,
                              input int unsigned max_steps);
    set_result_t res;
    logic [ELEM_W-1:0] cursor;
    cursor = start;
    for (int unsigned n = 0; n < max_steps; n++) begin
      add_item(OP_QUERY, kind, cursor, res);
      if (!res.found || res.next_member == '1) break;
      cursor = res.next_member + 1'b1;
    end
  endtask

  // Favor chunk edges and the ends of the universe
  function automatic logic [ELEM_W-1:0] pick_element();
    logic [ELEM_W-1:0] e;
    case ($urandom_range(0, 5))
      0: e = ELEM_W'($urandom_range(0, 15) * 8);
      1: e = ELEM_W'($urandom_range(0, 15) * 8 + 7);
      2: e = ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: e = ELEM_W'($urandom);
    endcase
    return e;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    return ($urandom_range(0, 15) == 0) ? KIND_UNUSED : KIND_W'($urandom_range(0, 2));
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    set_result_t r;
    int unsigned fill;

    // Directed opening: empty sets, ends of the universe, duplicates, every
    // kind including the unused one, and clear with the OR and the unused kind.
    add_item(OP_QUERY,  KIND_AND,    7'd0,   r);
    add_item(OP_INS_A,  KIND_OR,     7'd0,   r);
    add_item(OP_INS_A,  KIND_DIFF,   7'd127, r);
    add_item(OP_INS_B,  KIND_AND,    7'd127, r);
    add_item(OP_INS_B,  KIND_OR,     7'd64,  r);
    add_item(OP_INS_A,  KIND_AND,    7'd64,  r);
    add_item(OP_INS_A,  KIND_OR,     7'd64,  r);   // duplicate insert
    add_item(OP_INS_B,  KIND_DIFF,   7'd127, r);   // duplicate insert
    add_item(OP_INS_A,  KIND_DIFF,   7'd7,   r);
    add_item(OP_INS_B,  KIND_OR,     7'd8,   r);
    add_item(OP_QUERY,  KIND_UNUSED, 7'd0,   r);
    add_item(OP_INS_B,  KIND_UNUSED, 7'd1,   r);
    add_item(OP_QUERY,  KIND_DIFF,   7'd1,   r);
    add_item(OP_QUERY,  KIND_DIFF,   7'd8,   r);
    add_item(OP_QUERY,  KIND_OR,     7'd127, r);
    add_item(OP_QUERY,  KIND_AND,    7'd65,  r);
    walk_members(KIND_OR, 7'd0, 6);
    add_item(OP_CLEAR,  KIND_OR,     7'd0,   r);
    add_item(OP_QUERY,  KIND_OR,     7'd0,   r);
    add_item(OP_CLEAR,  KIND_UNUSED, 7'd127, r);

    // Dense phase: fill much of the first set so counts run high
    for (int unsigned i = 0; i < UNIVERSE; i++) begin
      add_item(OP_INS_A, pick_kind(), ELEM_W'(($urandom_range(0, 1) != 0) ? i : 127 - i), r);
      if (i % 2 == 0) add_item(OP_INS_B, pick_kind(), ELEM_W'(i), r);
    end
    add_item(OP_QUERY, KIND_OR, 7'd0, r);
    walk_members(KIND_DIFF, 7'd0, 20);
    walk_members(KIND_AND, 7'd100, 20);

    // Random phases: usually clear, then fill and enumerate, with stray items mixed in
    while (items_total < ITEM_TARGET) begin
      if ($urandom_range(0, 3) != 0) add_item(OP_CLEAR, pick_kind(), pick_element(), r);
      fill = $urandom_range(0, 40);
      for (int unsigned i = 0; i < fill; i++) begin
        add_item(($urandom_range(0, 1) != 0) ? OP_INS_A : OP_INS_B, pick_kind(),
                 pick_element(), r);
      end
      walk_members(KIND_W'($urandom_range(0, 2)),
                   ($urandom_range(0, 2) == 0) ? pick_element() : '0,
                   $urandom_range(4, 30));
      for (int unsigned i = $urandom_range(0, 3); i > 0; i--) begin
        add_item(OP_W'($urandom_range(0, 3)), pick_kind(), pick_element(), r);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_accepted < items_total || expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Checked %0d results from %0d items (%0d clears, %0d queries).",
             results_seen, items_accepted, clears_sent, queries_sent);
    $display("Largest member count %0d, searches with no member found %0d.",
             max_count_seen, misses_seen);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: hold an item until taken, send in bursts, predict on acceptance
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    set_item_t taken;
    logic      handshake;
    handshake = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (handshake) begin
      taken = pending_items.pop_front();
      apply_set_op(taken, first_bits, second_bits);
      expected_results.push_back(derive_set_result(first_bits, second_bits,
                                                   taken.set_kind, taken.element));
      items_accepted++;
      if (taken.op == OP_CLEAR) clears_sent++;
      if (taken.op == OP_QUERY) queries_sent++;
    end
    // Keep an offered item in place until it is taken
    if (rst_ni && !(s_axis_tvalid_i && !handshake)) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= IN_TDATA_W'({pending_items[0].element,
                                        pending_items[0].set_kind,
                                        pending_items[0].op});
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: rotate a ready pattern, reloaded now and then; an all-ones
  // pattern gives stretches with no stall, all-zeros a long one.
  // --------------------------------------------------------------------------
  logic [7:0]  ready_pattern = 8'hFF;
  int unsigned reload_left   = 0;

  always @(posedge clk_i) begin
    logic [7:0] nxt;
    if (reload_left == 0) begin
      case ($urandom_range(0, 4))
        0:       nxt = 8'hFF;
        1:       nxt = 8'h01 << $urandom_range(0, 7);
        2:       nxt = 8'h00;
        default: nxt = 8'($urandom);
      endcase
      reload_left <= (nxt == 8'h00) ? $urandom_range(8, 40) : $urandom_range(16, 96);
    end else begin
      nxt = {ready_pattern[0], ready_pattern[7:1]};
      reload_left <= reload_left - 1;
    end
    ready_pattern   <= nxt;
    m_axis_tready_i <= nxt[0];
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    set_result_t got;
    set_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      results_seen++;
      if (got.member_count > max_count_seen) max_count_seen = got.member_count;
      if (!got.found) misses_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: tdata 0x%04h", m_axis_tdata_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.member_count !== want.member_count) begin
          $error("member_count: expected %0d, got %0d", want.member_count, got.member_count);
          error_count++;
        end
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          error_count++;
        end
        if (got.next_member !== want.next_member) begin
          $error("next_member: expected %0d, got %0d", want.next_member, got.next_member);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d items accepted.",
               cycle_count, items_accepted, items_total);
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
